>>> rtl/core/rhf_pkg.sv
`default_nettype none
package rhf_pkg;

    // Sizes
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int VAL_W         = 8;
    localparam int HGT_W         = 32;
    localparam int IMG_W_W       = 13;
    localparam int IMG_H_W       = 16;
    localparam int TOL_W         = 31;
    localparam int CFG_W         = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int RING_N        = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int ACC_W         = 38;   // weighted sums of up to eight samples
    localparam int DIST_W        = 40;   // distance to the weighted mean z
    localparam int DIV_W         = 36;   // dividend magnitude
    localparam int KW_W          = 4;    // weight sum, at most 12
    localparam int KV_W          = 12;   // weighted value sum, at most 3060
    localparam int CNT_W         = 6;

    // Reset values of the configuration registers
    localparam logic [IMG_W_W-1:0] IMG_W_RST = 13'd4096;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd4096;
    localparam logic [TOL_W-1:0]   Z_TOL_RST = 31'd3277;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_Z_TOLERANCE  = 2'd2
    } cfg_idx_t;

    // Window tap of each ring place, clockwise from the top-left
    localparam logic [3:0] RING_TAP [RING_N] = '{4'd0, 4'd1, 4'd2, 4'd5,
                                                 4'd8, 4'd7, 4'd6, 4'd3};
    localparam int CENTRE_TAP = 4;

    // One pixel, value in the lowest bits
    typedef struct packed {
        logic signed [HGT_W-1:0] h;
        logic signed [HGT_W-1:0] z;
        logic [VAL_W-1:0]        v;
    } pix_t;

    // One classified window handed from the front to the back
    typedef struct packed {
        logic                                hole;
        logic [RING_N-1:0][VAL_W-1:0]        v;
        logic [RING_N-1:0][HGT_W-1:0]        z;
        logic [RING_N-1:0][HGT_W-1:0]        h;
    } ring_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_NEAR,
        B_KEEP,
        B_PREP,
        B_DIV,
        B_DONE
    } back_state_t;

    // True when two candidates lie three to five ring places apart
    function automatic logic ring_framed(input logic [RING_N-1:0] cand);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < RING_N; i++) begin
            for (int k = i + 3; k < RING_N && k <= i + 5; k++) begin
                if (cand[i] && cand[k]) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // One restoring division step: returns {remainder, shifted dividend/quotient}
    function automatic logic [KW_W+DIV_W-1:0] div_step(input logic [DIV_W-1:0] num,
                                                       input logic [KW_W-1:0]  rem,
                                                       input logic [KW_W-1:0]  dvs);
        logic [KW_W:0]   trial;
        logic [KW_W-1:0] rem_new;
        logic            qbit;
        trial = {rem, num[DIV_W-1]};
        if (trial >= {1'b0, dvs}) begin
            rem_new = KW_W'(trial - {1'b0, dvs});
            qbit    = 1'b1;
        end else begin
            rem_new = trial[KW_W-1:0];
            qbit    = 1'b0;
        end
        return {rem_new, num[DIV_W-2:0], qbit};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/rhf_ram.sv
`default_nettype none
module rhf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output      logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/rhf_front.sv
`default_nettype none
module rhf_front #(
    parameter int MaxWidth = rhf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire rhf_pkg::pix_t                s_pix,
    input  wire logic [rhf_pkg::IMG_W_W-1:0]  image_width,
    input  wire logic [rhf_pkg::IMG_H_W-1:0]  image_height,
    input  wire logic                         q_full,
    output      logic                         q_push,
    output      rhf_pkg::ring_t               q_entry
);
    import rhf_pkg::*;

    localparam int CW = (MaxWidth > 2) ? $clog2(MaxWidth) : 1;
    localparam int PW = $bits(pix_t);

    logic [CW-1:0]      col_reg, col_next;
    logic [IMG_H_W-1:0] row_reg, row_next;
    logic               rd_ok_reg;
    logic               accept;
    pix_t               rd_a, rd_b;
    pix_t               win_reg [9];
    pix_t               win_next [9];
    pix_t               new_col [3];
    logic [16:0]        w17, c17, r17, h17;
    logic               hole;

    assign accept  = s_valid && s_ready;
    assign s_ready = rd_ok_reg && !q_full;

    // Line store of row r-1 and of row r-2
    rhf_ram #(.Width(PW), .Depth(MaxWidth)) u_line_a (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_pix),
        .rd_addr (col_reg),
        .rd_data (rd_a)
    );

    rhf_ram #(.Width(PW), .Depth(MaxWidth)) u_line_b (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (rd_a),
        .rd_addr (col_reg),
        .rd_data (rd_b)
    );

    // Shift the window left and bring in the new column
    always_comb begin
        new_col[0] = rd_b;
        new_col[1] = rd_a;
        new_col[2] = s_pix;
        for (int i = 0; i < 3; i++) begin
            win_next[i*3]     = win_reg[i*3+1];
            win_next[i*3 + 1] = win_reg[i*3+2];
            win_next[i*3 + 2] = new_col[i];
        end
    end

    // Classify the centre
    always_comb begin
        w17  = (17'(image_width) > 17'(MaxWidth)) ? 17'(MaxWidth) : 17'(image_width);
        c17  = 17'(col_reg);
        r17  = 17'(row_reg);
        h17  = 17'(image_height);
        hole = (win_next[CENTRE_TAP].v == '0) && (r17 >= 17'd2) && (c17 >= 17'd2) &&
               (r17 + 17'd2 <= h17) && (c17 + 17'd2 <= w17);
        q_entry.hole = hole;
        for (int k = 0; k < RING_N; k++) begin
            q_entry.v[k] = win_next[RING_TAP[k]].v;
            q_entry.z[k] = win_next[RING_TAP[k]].z;
            q_entry.h[k] = win_next[RING_TAP[k]].h;
        end
    end

    assign q_push = accept;

    // Advance the raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (c17 + 17'd1 >= w17) begin
                col_next = '0;
                if (r17 + 17'd1 >= h17) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = CW'(c17 + 17'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            // line store read data is stale in the cycle after each write
            rd_ok_reg <= !accept;
        end
    end

    // Window taps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/rhf_queue.sv
`default_nettype none
module rhf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire rhf_pkg::ring_t push_data,
    input  wire logic           pop,
    output      rhf_pkg::ring_t pop_data,
    output      logic           full,
    output      logic           empty
);
    import rhf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    ring_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/rhf_back.sv
`default_nettype none
module rhf_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_empty,
    input  wire rhf_pkg::ring_t             q_entry,
    output      logic                       q_pop,
    input  wire logic [rhf_pkg::TOL_W-1:0]  z_tolerance,
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic                       m_filled,
    output      rhf_pkg::pix_t              m_pix
);
    import rhf_pkg::*;

    back_state_t state_reg, state_next;

    logic [RING_N-1:0][VAL_W-1:0] rv_reg, rv_next;
    logic [RING_N-1:0][HGT_W-1:0] rz_reg, rz_next;
    logic [RING_N-1:0][HGT_W-1:0] rh_reg, rh_next;
    logic [RING_N-1:0]            cand_reg, cand_next;
    logic [2:0]                   idx_reg, idx_next;
    logic [KW_W-1:0]              sw_reg, sw_next;
    logic signed [ACC_W-1:0]      sz_reg, sz_next;
    logic [DIST_W-1:0]            best_reg, best_next;
    logic                         found_reg, found_next;
    logic signed [HGT_W-1:0]      zref_reg, zref_next;
    logic [KW_W-1:0]              kw_reg, kw_next;
    logic [KV_W-1:0]              kv_reg, kv_next;
    logic signed [ACC_W-1:0]      kz_reg, kz_next;
    logic signed [ACC_W-1:0]      kh_reg, kh_next;
    logic [DIV_W-1:0]             nv_reg, nv_next, nz_reg, nz_next, nh_reg, nh_next;
    logic [KW_W-1:0]              remv_reg, remv_next, remz_reg, remz_next;
    logic [KW_W-1:0]              remh_reg, remh_next;
    logic                         negz_reg, negz_next, negh_reg, negh_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         fill_reg, fill_next;
    logic                         mval_reg, mval_next;
    logic                         mfill_reg;
    pix_t                         mpix_reg;
    logic                         out_load;

    // Current ring place
    logic signed [HGT_W-1:0]  cz, ch;
    logic [VAL_W-1:0]         cv;
    logic                     is_cand, heavy;
    logic signed [ACC_W-1:0]  cz_ext, ch_ext, czw, chw;
    logic signed [36:0]       prod;
    logic signed [DIST_W-1:0] diff;
    logic [DIST_W-1:0]        near_gap;
    logic signed [HGT_W:0]    dz;
    logic [HGT_W:0]           adz;
    logic                     keep;
    logic [KW_W-1:0]          wt;
    logic [KV_W-1:0]          cvw;
    logic [RING_N-1:0]        entry_cand;
    logic [DIV_W-1:0]         akz, akh;
    logic [KW_W+DIV_W-1:0]    stv, stz, sth;
    pix_t                     res_pix;

    always_comb begin
        cz      = rz_reg[idx_reg];
        ch      = rh_reg[idx_reg];
        cv      = rv_reg[idx_reg];
        is_cand = cand_reg[idx_reg];
        heavy   = !idx_reg[0];
        wt      = heavy ? KW_W'(2) : KW_W'(1);
        cz_ext  = ACC_W'(cz);
        ch_ext  = ACC_W'(ch);
        czw     = heavy ? (cz_ext <<< 1) : cz_ext;
        chw     = heavy ? (ch_ext <<< 1) : ch_ext;
        cvw     = heavy ? (KV_W'(cv) << 1) : KV_W'(cv);
        // distance of this candidate from the weighted mean, scaled by the weight sum
        prod    = cz * $signed({1'b0, sw_reg});
        diff    = DIST_W'(prod) - DIST_W'(sz_reg);
        near_gap = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
        dz      = (HGT_W+1)'(cz) - (HGT_W+1)'(zref_reg);
        adz     = dz[HGT_W] ? (HGT_W+1)'(-dz) : (HGT_W+1)'(dz);
        keep    = is_cand && (adz < (HGT_W+1)'(z_tolerance));
        for (int k = 0; k < RING_N; k++) begin
            entry_cand[k] = (q_entry.v[k] != '0);
        end
        akz     = kz_reg[ACC_W-1] ? DIV_W'(-kz_reg) : DIV_W'(kz_reg);
        akh     = kh_reg[ACC_W-1] ? DIV_W'(-kh_reg) : DIV_W'(kh_reg);
        stv     = div_step(nv_reg, remv_reg, kw_reg);
        stz     = div_step(nz_reg, remz_reg, kw_reg);
        sth     = div_step(nh_reg, remh_reg, kw_reg);
    end

    // Assemble the result
    always_comb begin
        if (fill_reg) begin
            res_pix.v = nv_reg[VAL_W-1:0];
            res_pix.z = negz_reg ? -nz_reg[HGT_W-1:0] : nz_reg[HGT_W-1:0];
            res_pix.h = negh_reg ? -nh_reg[HGT_W-1:0] : nh_reg[HGT_W-1:0];
        end else begin
            res_pix = '0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_entry.hole && ring_framed(entry_cand)) ? B_SUM : B_DONE;
                end
            end
            B_SUM:  if (idx_reg == 3'd7) state_next = B_NEAR;
            B_NEAR: if (idx_reg == 3'd7) state_next = B_KEEP;
            B_KEEP: if (idx_reg == 3'd7) state_next = B_PREP;
            B_PREP: state_next = (kw_reg == '0) ? B_DONE : B_DIV;
            B_DIV:  if (cnt_reg == CNT_W'(DIV_W - 1)) state_next = B_DONE;
            B_DONE: if (!mval_reg || m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        out_load = (state_reg == B_DONE) && (!mval_reg || m_ready);
    end

    // Datapath
    always_comb begin
        rv_next    = rv_reg;
        rz_next    = rz_reg;
        rh_next    = rh_reg;
        cand_next  = cand_reg;
        idx_next   = idx_reg;
        sw_next    = sw_reg;
        sz_next    = sz_reg;
        best_next  = best_reg;
        found_next = found_reg;
        zref_next  = zref_reg;
        kw_next    = kw_reg;
        kv_next    = kv_reg;
        kz_next    = kz_reg;
        kh_next    = kh_reg;
        nv_next    = nv_reg;
        nz_next    = nz_reg;
        nh_next    = nh_reg;
        remv_next  = remv_reg;
        remz_next  = remz_reg;
        remh_next  = remh_reg;
        negz_next  = negz_reg;
        negh_next  = negh_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        unique case (state_reg)
            B_IDLE: begin
                // take the next window and clear the sums
                if (!q_empty) begin
                    rv_next    = q_entry.v;
                    rz_next    = q_entry.z;
                    rh_next    = q_entry.h;
                    cand_next  = entry_cand;
                    idx_next   = '0;
                    sw_next    = '0;
                    sz_next    = '0;
                    found_next = 1'b0;
                    kw_next    = '0;
                    kv_next    = '0;
                    kz_next    = '0;
                    kh_next    = '0;
                    fill_next  = 1'b0;
                end
            end
            B_SUM: begin
                if (is_cand) begin
                    sw_next = sw_reg + wt;
                    sz_next = sz_reg + czw;
                end
                idx_next = idx_reg + 1'b1;
            end
            B_NEAR: begin
                // first candidate wins a tie
                if (is_cand && (!found_reg || near_gap < best_reg)) begin
                    best_next  = near_gap;
                    zref_next  = cz;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            B_KEEP: begin
                if (keep) begin
                    kw_next = kw_reg + wt;
                    kv_next = kv_reg + cvw;
                    kz_next = kz_reg + czw;
                    kh_next = kh_reg + chw;
                end
                idx_next = idx_reg + 1'b1;
            end
            B_PREP: begin
                nv_next   = DIV_W'(kv_reg);
                nz_next   = akz;
                nh_next   = akh;
                negz_next = kz_reg[ACC_W-1];
                negh_next = kh_reg[ACC_W-1];
                remv_next = '0;
                remz_next = '0;
                remh_next = '0;
                cnt_next  = '0;
                fill_next = (kw_reg != '0);
            end
            B_DIV: begin
                {remv_next, nv_next} = stv;
                {remz_next, nz_next} = stz;
                {remh_next, nh_next} = sth;
                cnt_next = cnt_reg + 1'b1;
            end
            B_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register handshake
    always_comb begin
        mval_next = mval_reg;
        if (out_load) begin
            mval_next = 1'b1;
        end else if (m_ready) begin
            mval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        rv_reg    <= rv_next;
        rz_reg    <= rz_next;
        rh_reg    <= rh_next;
        cand_reg  <= cand_next;
        idx_reg   <= idx_next;
        sw_reg    <= sw_next;
        sz_reg    <= sz_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        zref_reg  <= zref_next;
        kw_reg    <= kw_next;
        kv_reg    <= kv_next;
        kz_reg    <= kz_next;
        kh_reg    <= kh_next;
        nv_reg    <= nv_next;
        nz_reg    <= nz_next;
        nh_reg    <= nh_next;
        remv_reg  <= remv_next;
        remz_reg  <= remz_next;
        remh_reg  <= remh_next;
        negz_reg  <= negz_next;
        negh_reg  <= negh_next;
        cnt_reg   <= cnt_next;
        fill_reg  <= fill_next;
        if (out_load) begin
            mfill_reg <= fill_reg;
            mpix_reg  <= res_pix;
        end
    end

    assign m_valid  = mval_reg;
    assign m_filled = mfill_reg;
    assign m_pix    = mpix_reg;

endmodule
`default_nettype wire

>>> rtl/core/raster_hole_filler_3x3_top.sv
`default_nettype none
// 3x3 hole filler for a raster pixel stream. Each input beat carries one pixel
// (value, signed Q16.16 z and h); each input beat gives exactly one output beat,
// which refers to the pixel one row and one column behind. The front keeps two
// line stores and the window and stalls the input after each accepted pixel,
// since the registered line store read is reissued after each write. A two-entry
// queue separates it from the back sequencer, which passes a pixel that is no
// fillable hole straight on and, for a hole, makes three 8-step passes over the
// ring (weighted mean z, nearest candidate, kept sums) and a 36-step restoring
// divider when a candidate is kept. The back sequencer sets sustained throughput.
// Write image_width, image_height and z_tolerance only while the block is idle.
module raster_hole_filler_3x3_top #(
    parameter int MAX_WIDTH = rhf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [71:0]                   s_axis_tdata,   // pixel_value, z_value, h_value
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [71:0]                   m_axis_tdata,   // fill_value, fill_z, fill_h
    output      logic [0:0]                    m_axis_tuser,   // filled
    input  wire logic                          cfg_wr_en,
    input  wire logic [rhf_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [rhf_pkg::CFG_W-1:0]     cfg_wr_data
);
    import rhf_pkg::*;

    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [TOL_W-1:0]   z_tolerance_reg;
    logic               q_push, q_pop, q_full, q_empty;
    ring_t              q_in, q_out;
    pix_t               s_pix, m_pix;
    logic               m_filled;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMG_W_RST;
            image_height_reg <= IMG_H_RST;
            z_tolerance_reg  <= Z_TOL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[IMG_H_W-1:0];
                CFG_Z_TOLERANCE:  z_tolerance_reg  <= cfg_wr_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_pix = pix_t'(s_axis_tdata);

    rhf_front #(.MaxWidth(MAX_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_pix        (s_pix),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    rhf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    rhf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_entry     (q_out),
        .q_pop       (q_pop),
        .z_tolerance (z_tolerance_reg),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_filled    (m_filled),
        .m_pix       (m_pix)
    );

    assign m_axis_tdata = 72'(m_pix);
    assign m_axis_tuser = m_filled;

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("window queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty) else $error("window queue underflow");

    // An unfilled pixel carries zero fields
    a_unfilled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("unfilled result with non-zero fields");

endmodule
`default_nettype wire
